/* design/gtpu_header_length_parser_core_assert.svh */
// Assertion macros for the GTP-U header length parser.
`ifndef GTPU_HEADER_LENGTH_PARSER_CORE_ASSERT_SVH
`define GTPU_HEADER_LENGTH_PARSER_CORE_ASSERT_SVH

`ifndef SYNTH
`define GHLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define GHLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GHLP_ASSERT_NOW(lbl, ante, cons, msg)
`define GHLP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* design/gtpu_hlp_pkg.sv */
`timescale 1ns / 1ps
package gtpu_hlp_pkg;

  localparam logic [15:0] GTP_BASE_LEN = 16'd8;
  localparam logic [15:0] GTP_OPT_LEN  = 16'd12;
  localparam logic [15:0] MAX_LEN      = 16'hFFFF;
  localparam logic [2:0]  GTP_VERSION  = 3'd1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_BAD_VER  = 2'd2,
    ST_ZERO_EXT = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [15:0] header_len;
    status_t     status;
  } out_word_t;

  typedef struct packed {
    logic [15:0] byte_index;
    logic [15:0] needed_len;
    logic        version_bad;
    logic        chain_active;
    logic        await_ext_length;
    logic        result_given;
  } parse_state_t;

endpackage

/* design/gtpu_header_length_parser_core.sv */
`timescale 1ns / 1ps
// GTP-U header length parser. Takes one packet byte per word, starting at the
// GTP-U header, with last_byte on the final byte, and gives one word per
// packet: the header length including extension headers, or an error status
// with a length of zero. One byte is accepted every cycle while the output is
// not stalled; a result passes from the byte that decides it through the input
// register, the per-byte parse step and the result register.
module gtpu_header_length_parser_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  gtpu_hlp_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  logic                    out_ready,
  output gtpu_hlp_pkg::out_word_t out_word
);
  import gtpu_hlp_pkg::*;
  `include "gtpu_header_length_parser_core_assert.svh"

  logic         s1_valid;
  in_word_t     s1_word;
  parse_state_t st;
  parse_state_t st_next;
  logic         res_valid;
  out_word_t    res;
  logic         advance;
  logic         out_load;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign out_load = s1_valid && advance && res_valid;

  gtpu_hlp_step u_step (
    .st        (st),
    .word      (s1_word),
    .st_next   (st_next),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_word <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{byte_index: 16'd0, needed_len: GTP_BASE_LEN, version_bad: 1'b0,
              chain_active: 1'b0, await_ext_length: 1'b0, result_given: 1'b0};
    end else if (s1_valid && advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && res_valid;
    end
    if (out_load) begin
      out_word <= res;
    end
  end

  `GHLP_ASSERT_NEXT(a_one_per_packet, out_load, st.result_given || (st.byte_index == 16'd0), "result given without marking packet done")
  `GHLP_ASSERT_NOW(a_err_zero_len, out_valid && (out_word.status != ST_OK), out_word.header_len == 16'd0, "error word with nonzero length")
  `GHLP_ASSERT_NOW(a_len_floor, 1'b1, st.needed_len >= GTP_BASE_LEN, "needed length below base header")

endmodule

/* design/gtpu_hlp_step.sv */
`timescale 1ns / 1ps
module gtpu_hlp_step (
  input  gtpu_hlp_pkg::parse_state_t st,
  input  gtpu_hlp_pkg::in_word_t     word,
  output gtpu_hlp_pkg::parse_state_t st_next,
  output logic                       res_valid,
  output gtpu_hlp_pkg::out_word_t    res
);
  import gtpu_hlp_pkg::*;

  always_comb begin
    parse_state_t s;
    logic [16:0]  ext_sum;
    logic [16:0]  idx_inc;
    logic [7:0]   b;

    b         = word.data_byte;
    s         = st;
    res_valid = 1'b0;
    res       = '{header_len: 16'd0, status: ST_OK};
    ext_sum   = 17'd0;
    idx_inc   = {1'b0, st.byte_index} + 17'd1;

    if (!st.result_given) begin
      if (st.byte_index == 16'd0) begin
        s.version_bad  = (b[7:5] != GTP_VERSION);
        s.chain_active = b[2];
        if (b[2] || (b[1:0] != 2'b00)) begin
          s.needed_len = GTP_OPT_LEN;
        end else begin
          s.needed_len = GTP_BASE_LEN;
        end
      end
      ext_sum = {1'b0, s.needed_len} + {7'd0, b, 2'b00};

      if ((st.byte_index == GTP_BASE_LEN - 16'd1) && s.version_bad) begin
        res_valid = 1'b1;
        res       = '{header_len: 16'd0, status: ST_BAD_VER};
      end else if (s.await_ext_length && (st.byte_index == s.needed_len)) begin
        if (b == 8'd0) begin
          res_valid = 1'b1;
          res       = '{header_len: 16'd0, status: ST_ZERO_EXT};
        end else begin
          if (ext_sum[16]) begin
            res_valid = 1'b1;
            res       = '{header_len: 16'd0, status: ST_TRUNC};
          end else begin
            s.needed_len = ext_sum[15:0];
          end
          s.await_ext_length = 1'b0;
        end
      end else if (!s.await_ext_length && (idx_inc == {1'b0, s.needed_len})) begin
        if (s.chain_active && (b != 8'd0)) begin
          s.await_ext_length = 1'b1;
        end else begin
          res_valid = 1'b1;
          res       = '{header_len: s.needed_len, status: ST_OK};
        end
      end

      if (word.last_byte && !res_valid) begin
        res_valid = 1'b1;
        res       = '{header_len: 16'd0, status: ST_TRUNC};
      end
      if (res_valid) begin
        s.result_given = 1'b1;
      end
    end

    if (word.last_byte) begin
      s = '{byte_index: 16'd0, needed_len: GTP_BASE_LEN, version_bad: 1'b0,
            chain_active: 1'b0, await_ext_length: 1'b0, result_given: 1'b0};
    end else if (st.byte_index != MAX_LEN) begin
      s.byte_index = idx_inc[15:0];
    end

    st_next = s;
  end

endmodule
